// File: rtl/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// shared types and constants of the combined lcg range random unit
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int unsigned SeedW  = 31;
  localparam int unsigned ValW   = 64;
  localparam int unsigned QDepth = 2;

  localparam logic [30:0] ModA     = 31'd2147483563 - 31'd0;
  localparam logic [30:0] ModB     = 31'd2147483399;
  localparam logic [15:0] MulA     = 16'd40014;
  localparam logic [15:0] MulB     = 16'd40692;
  localparam logic [13:0] AddA     = 14'd12211;
  localparam logic [13:0] AddB     = 14'd3791;
  localparam logic [30:0] DefaultA = 31'd12345;
  localparam logic [30:0] DefaultB = 31'd67890;

  typedef enum logic [1:0] {
    RegSeedANarrow = 2'd0,
    RegSeedBNarrow = 2'd1,
    RegSeedAWide   = 2'd2,
    RegSeedBWide   = 2'd3
  } reg_idx_e;

  // classified work item handed from front to back
  typedef struct packed {
    logic            mode;
    logic            active;   // range positive, generator must advance
    logic [ValW-1:0] low;
    logic [ValW-1:0] divisor;  // range + 1, masked to the mode width
  } job_t;

endpackage

// File: rtl/clr_front.sv
// ----------------------------------------------------------------------------
// clr_front
// computes range, classifies requests and pushes them into a small queue
// ----------------------------------------------------------------------------
module clr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [63:0]        low_i,
  input  logic [63:0]        high_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output clr_pkg::job_t      job_o
);
  import clr_pkg::*;

  job_t        mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic [63:0] lo, rng;
  job_t        job_d;
  logic        push, pop;

  always_comb begin
    lo  = mode_i ? low_i : {{32{low_i[31]}}, low_i[31:0]};
    rng = high_i - low_i;
    job_d.mode = mode_i;
    job_d.low  = lo;
    if (mode_i) begin
      job_d.active  = (rng != 64'd0) && !rng[63];
      job_d.divisor = rng + 64'd1;
    end else begin
      job_d.active  = (rng[31:0] != 32'd0) && !rng[31];
      job_d.divisor = {32'd0, rng[31:0] + 32'd1};
    end
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/clr_back.sv
// ----------------------------------------------------------------------------
// clr_back
// advances the generators, reduces by a restoring divider, adds low
// ----------------------------------------------------------------------------
module clr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [30:0]    cfg_val_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  clr_pkg::job_t  job_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [63:0]    res_o
);
  import clr_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001, StMul = 5'b00010, StRed = 5'b00100,
    StDiv  = 5'b01000, StOut = 5'b10000
  } state_e;

  state_e      st_q;
  logic [30:0] na_q, nb_q, wa_q, wb_q;
  job_t        job_q;
  logic [46:0] pa_q, pb_q;
  logic [30:0] ra_q, rb_q;
  logic [5:0]  cnt_q;
  logic [30:0] quo_q;     // dividend bits shifted out msb first
  logic [63:0] rem_q;
  logic [63:0] res_q;
  logic        vld_q;
  logic [30:0] sa, sb, na, nb, mag;
  logic [64:0] trial;
  logic [63:0] sum;

  assign sa = job_q.mode ? wa_q : na_q;
  assign sb = job_q.mode ? wb_q : nb_q;

  // 47-bit products reduced by at most three subtracts after a coarse fold
  function automatic logic [30:0] mod_red(input logic [46:0] p, input logic [30:0] m);
    logic [47:0] r;
    logic [16:0] hq;
    hq = p[46:30];
    // p = hi*2^31 + lo ; 2^30 < m < 2^31 so fold hi via 2^31-m, then compare
    r = {1'b0, p};
    r = 48'(p[46:31]) * 48'(32'h80000000 - {1'b0, m}) + 48'(p[30:0]);
    if (hq == 17'd0) r = {1'b0, p};
    if (r >= 48'(m)) r = r - 48'(m);
    if (r >= 48'(m)) r = r - 48'(m);
    if (r >= 48'(m)) r = r - 48'(m);
    return r[30:0];
  endfunction

  assign na = mod_red(pa_q, ModA);
  assign nb = mod_red(pb_q, ModB);
  assign mag = (ra_q >= rb_q) ? ra_q - rb_q : rb_q - ra_q;
  assign trial = {rem_q, quo_q[30]} - {1'b0, job_q.divisor};
  assign sum = job_q.low + rem_q;

  assign job_ready_o = (st_q == StIdle);
  assign res_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (job_valid_i && st_q == StIdle) job_q <= job_i;
    if (st_q == StMul) begin
      pa_q <= 47'(sa) * 47'(MulA) + 47'(AddA);
      pb_q <= 47'(sb) * 47'(MulB) + 47'(AddB);
    end
    if (st_q == StRed) begin
      ra_q <= na; rb_q <= nb;
      quo_q <= 31'd0; rem_q <= 64'd0;
    end
    if (st_q == StDiv) begin
      if (cnt_q == 6'd0) quo_q <= mag;
      else begin
        quo_q <= {quo_q[29:0], 1'b0};
        rem_q <= trial[64] ? {rem_q[62:0], quo_q[30]} : trial[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; vld_q <= 1'b0; cnt_q <= 6'd0;
      na_q <= DefaultA; nb_q <= DefaultB; wa_q <= DefaultA; wb_q <= DefaultB;
      res_q <= 64'd0;
    end else begin
      if (st_q == StOut && (!vld_q || res_ready_i)) vld_q <= 1'b1;
      else if (res_ready_i) vld_q <= 1'b0;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegSeedANarrow: na_q <= (cfg_val_i == 31'd0) ? DefaultA : cfg_val_i;
          RegSeedBNarrow: nb_q <= (cfg_val_i == 31'd0) ? DefaultB : cfg_val_i;
          RegSeedAWide:   wa_q <= (cfg_val_i == 31'd0) ? DefaultA : cfg_val_i;
          RegSeedBWide:   wb_q <= (cfg_val_i == 31'd0) ? DefaultB : cfg_val_i;
          default: ;
        endcase
      end
      case (st_q)
        StIdle: if (job_valid_i) st_q <= job_i.active ? StMul : StOut;
        StMul:  st_q <= StRed;
        StRed: begin
          st_q <= StDiv; cnt_q <= 6'd0;
          if (job_q.mode) begin wa_q <= na; wb_q <= nb; end
          else begin na_q <= na; nb_q <= nb; end
        end
        StDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) st_q <= StOut;
        end
        StOut: if (!vld_q || res_ready_i) begin
          if (!job_q.active) res_q <= job_q.low;
          else if (job_q.mode) res_q <= sum;
          else res_q <= {{32{sum[31]}}, sum[31:0]};
          st_q  <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// File: rtl/combined_lcg_range_random_unit.sv
// ----------------------------------------------------------------------------
// combined_lcg_range_random_unit
// range-bounded random numbers from two combined lcg generators per width
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tdata = mode[0], low_bound[64:1], high_bound[128:65], pad
// m_axis    out  tdata = random_value[63:0]
// cfg       in   index[1:0], data[30:0] seed
// a positive-range beat steps through the lcg multiply and reduce states, the
// remainder divider (the offset is below 2^31) and the output state.
// a non-positive range beat goes straight to the output state.
// a two-entry queue lets the front take beats while the back computes.
// reset loads the default seeds; results wait in an output register.
// ----------------------------------------------------------------------------
module combined_lcg_range_random_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // mode, low_bound, high_bound, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // random_value
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);
  import clr_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  assign cfg_ready_o = 1'b1;

  clr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .mode_i (s_axis_tdata[0]), .low_i (s_axis_tdata[64:1]),
    .high_i (s_axis_tdata[128:65]),
    .job_valid_o (job_valid), .job_ready_i (job_ready), .job_o (job)
  );

  clr_back u_back (
    .clk_i, .rst_ni,
    .cfg_we_i (cfg_valid_i), .cfg_idx_i (cfg_index_i), .cfg_val_i (cfg_data_i),
    .job_valid_i (job_valid), .job_ready_o (job_ready), .job_i (job),
    .res_valid_o (m_axis_tvalid), .res_ready_i (m_axis_tready),
    .res_o (m_axis_tdata)
  );

  // a held result must not change while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // a result stays offered until the sink takes it
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");
endmodule
